[hw/rtl/svbi_pkg.sv]
// Shared types, codes and constants for the solenoid valve bank interlock.
`timescale 1ns / 1ps
`default_nettype none
package svbi_pkg;

   localparam int unsigned MASK_WIDTH = 8;
   localparam int unsigned STAMP_WIDTH = 32;
   localparam int unsigned MIN_WIDTH = 16;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Reset values of the configuration registers
   localparam logic [15:0] MIN_MAIN_RESET = 16'd100;
   localparam logic [31:0] MAX_MAIN_RESET = 32'd300000;
   localparam logic [15:0] MIN_VENT_RESET = 16'd50;
   localparam logic [31:0] MAX_VENT_RESET = 32'd60000;
   localparam logic [15:0] MIN_CIRC_RESET = 16'd100;
   localparam logic [31:0] MAX_CIRC_RESET = 32'd600000;
   localparam logic [7:0] NO_MASK_RESET = 8'd48;

   // ms -> s: floor(x / 1000) = floor((x >> 3) * DIV_MULT >> DIV_SHIFT), exact for 32-bit x
   localparam logic [29:0] DIV_MULT = 30'd549755814;
   localparam int unsigned DIV_SHIFT = 36;
   localparam int unsigned PROD_WIDTH = 59;

   typedef enum logic [2:0] {
      OP_SET         = 3'd0,
      OP_ENABLE      = 3'd1,
      OP_CLEAR_FAULT = 3'd2,
      OP_EMERGENCY   = 3'd3,
      OP_BATCH       = 3'd4,
      OP_QUERY       = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_MIN_MAIN = 3'd0,
      CSR_MAX_MAIN = 3'd1,
      CSR_MIN_VENT = 3'd2,
      CSR_MAX_VENT = 3'd3,
      CSR_MIN_CIRC = 3'd4,
      CSR_MAX_CIRC = 3'd5,
      CSR_NO_MASK  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      GRP_MAIN = 2'd0,
      GRP_VENT = 2'd1,
      GRP_CIRC = 2'd2
   } group_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_ADD  = 2'd2,
      ST_DONE = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic        take;
      logic [2:0]  op;
      logic        hit;
      logic        open_cmd;
      logic        en_cmd;
      logic        sel;
      logic        batch_open;
      logic [31:0] now;
      logic        acc;
   } lane_ctl_type;

   typedef struct packed {
      logic        is_open;
      logic        enabled;
      logic        fault;
      logic        start_valid;
      logic [31:0] start_stamp;
      logic [31:0] count;
      logic [31:0] total;
   } lane_stat_type;

   typedef struct packed {
      logic [7:0]  drive_mask;
      logic [7:0]  open_state_mask;
      logic        valve_open;
      logic        valve_enabled;
      logic        valve_fault;
      logic [31:0] action_total;
      logic [31:0] open_seconds;
   } rsp_data_type;

   function automatic group_type group_of(input int unsigned v);
      group_type g;
      if (v < 4) begin
         g = GRP_MAIN;
      end else if (v < 6) begin
         g = GRP_VENT;
      end else begin
         g = GRP_CIRC;
      end
      return g;
   endfunction

   function automatic logic [PROD_WIDTH-1:0] ms_product(input logic [31:0] ms);
      logic [28:0] eighths;
      eighths = ms[31:3];
      return PROD_WIDTH'({30'd0, eighths} * {29'd0, DIV_MULT});
   endfunction

   function automatic logic [31:0] sec_of_product(input logic [PROD_WIDTH-1:0] prod);
      return {9'd0, prod[PROD_WIDTH-1:DIV_SHIFT]};
   endfunction

endpackage
`default_nettype wire

[hw/rtl/svbi_if.sv]
// Request and response channel interfaces of the valve bank interlock.
`timescale 1ns / 1ps
`default_nettype none
interface svbi_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  valve_index;
   logic        open_command;
   logic        enable_command;
   logic [7:0]  select_mask;
   logic [7:0]  batch_open_bits;
   logic [31:0] now_ms;

   modport source (
      output valid, opcode, valve_index, open_command, enable_command,
             select_mask, batch_open_bits, now_ms,
      input  ready
   );
   modport sink (
      input  valid, opcode, valve_index, open_command, enable_command,
             select_mask, batch_open_bits, now_ms,
      output ready
   );
endinterface

interface svbi_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  drive_mask;
   logic [7:0]  open_state_mask;
   logic        valve_open;
   logic        valve_enabled;
   logic        valve_fault;
   logic [31:0] action_total;
   logic [31:0] open_seconds;

   modport source (
      output valid, drive_mask, open_state_mask, valve_open, valve_enabled,
             valve_fault, action_total, open_seconds,
      input  ready
   );
   modport sink (
      input  valid, drive_mask, open_state_mask, valve_open, valve_enabled,
             valve_fault, action_total, open_seconds,
      output ready
   );
endinterface
`default_nettype wire

[hw/rtl/svbi_lane.sv]
// One valve lane: interlock checks, state flags, stamps and counters.
`timescale 1ns / 1ps
`default_nettype none
module svbi_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   reset_open,
   input  wire logic [15:0]            min_ms,
   input  wire logic [31:0]            max_ms,
   input  wire svbi_pkg::lane_ctl_type ctl,
   output svbi_pkg::lane_stat_type     stat
);
   import svbi_pkg::*;

   logic        open_ff, open_in;
   logic        en_ff, en_in;
   logic        fault_ff, fault_in;
   logic        lc_valid_ff, lc_valid_in;
   logic [31:0] lc_stamp_ff, lc_stamp_in;
   logic        os_valid_ff, os_valid_in;
   logic [31:0] os_stamp_ff, os_stamp_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] total_ff, total_in;
   logic        pend_ff, pend_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;

   logic target, blocked, over, apply_go, apply_val;

   always_comb begin
      open_in     = open_ff;
      en_in       = en_ff;
      fault_in    = fault_ff;
      lc_valid_in = lc_valid_ff;
      lc_stamp_in = lc_stamp_ff;
      os_valid_in = os_valid_ff;
      os_stamp_in = os_stamp_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      pend_in     = pend_ff;
      elapsed_in  = elapsed_ff;
      prod_in     = ms_product(elapsed_ff);
      apply_go    = 1'b0;
      apply_val   = 1'b0;

      target  = (ctl.op == OP_SET) ? ctl.open_cmd : ctl.batch_open;
      blocked = !en_ff || fault_ff ||
                (lc_valid_ff && ((ctl.now - lc_stamp_ff) < {16'd0, min_ms}));
      over    = target && open_ff && os_valid_ff && ((ctl.now - os_stamp_ff) > max_ms);

      if (ctl.take) begin
         case (ctl.op)
            OP_SET, OP_BATCH: begin
               if (((ctl.op == OP_SET) ? ctl.hit : ctl.sel) && !blocked) begin
                  apply_go  = 1'b1;
                  apply_val = target && !over;
                  if (over) begin
                     fault_in = 1'b1;
                  end
               end
            end
            OP_ENABLE: begin
               if (ctl.hit) begin
                  // disable really closes the valve
                  apply_go  = !ctl.en_cmd;
                  en_in     = ctl.en_cmd;
               end
            end
            OP_CLEAR_FAULT: begin
               if (ctl.hit) begin
                  fault_in    = 1'b0;
                  lc_valid_in = 1'b0;
                  os_valid_in = 1'b0;
               end
            end
            OP_EMERGENCY: begin
               open_in  = 1'b0;
               fault_in = 1'b1;
            end
            default: begin
            end
         endcase

         if (apply_go && (open_ff != apply_val)) begin
            open_in     = apply_val;
            lc_stamp_in = ctl.now;
            lc_valid_in = 1'b1;
            count_in    = count_ff + 32'd1;
            if (apply_val) begin
               os_stamp_in = ctl.now;
               os_valid_in = 1'b1;
            end else if (os_valid_ff) begin
               // hold the finished period for the divider
               elapsed_in  = ctl.now - os_stamp_ff;
               pend_in     = 1'b1;
               os_valid_in = 1'b0;
            end
         end
      end

      if (ctl.acc && pend_ff) begin
         total_in = total_ff + sec_of_product(prod_ff);
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= reset_open;
         en_ff       <= 1'b1;
         fault_ff    <= 1'b0;
         lc_valid_ff <= 1'b0;
         os_valid_ff <= 1'b0;
         count_ff    <= 32'd0;
         total_ff    <= 32'd0;
         pend_ff     <= 1'b0;
      end else begin
         open_ff     <= open_in;
         en_ff       <= en_in;
         fault_ff    <= fault_in;
         lc_valid_ff <= lc_valid_in;
         os_valid_ff <= os_valid_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lc_stamp_ff <= lc_stamp_in;
      os_stamp_ff <= os_stamp_in;
      elapsed_ff  <= elapsed_in;
      prod_ff     <= prod_in;
   end

   assign stat.is_open     = open_ff;
   assign stat.enabled     = en_ff;
   assign stat.fault       = fault_ff;
   assign stat.start_valid = os_valid_ff;
   assign stat.start_stamp = os_stamp_ff;
   assign stat.count       = count_ff;
   assign stat.total       = total_ff;

endmodule
`default_nettype wire

[hw/rtl/svbi_merge.sv]
// Merge stage: pin and state masks, addressed-valve report and running open seconds.
`timescale 1ns / 1ps
`default_nettype none
module svbi_merge #(
   parameter int unsigned VALVE_COUNT = 8
) (
   input  wire logic                    clock,
   input  wire svbi_pkg::lane_stat_type stat [VALVE_COUNT],
   input  wire logic [2:0]              idx,
   input  wire logic [31:0]             now,
   input  wire logic [7:0]              no_mask,
   output svbi_pkg::rsp_data_type       result
);
   import svbi_pkg::*;

   lane_stat_type         pick;
   logic                  idx_ok;
   logic [7:0]            open_bits;
   logic [7:0]            drive_mask;
   logic [31:0]           elapsed_ff, elapsed_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;

   always_comb begin
      pick       = '0;
      idx_ok     = 1'b0;
      open_bits  = 8'd0;
      drive_mask = 8'd0;
      for (int v = 0; v < VALVE_COUNT; v++) begin
         open_bits[v]  = stat[v].is_open;
         drive_mask[v] = stat[v].is_open ^ no_mask[v];
         if (idx == 3'(v)) begin
            pick   = stat[v];
            idx_ok = 1'b1;
         end
      end
      elapsed_in = now - pick.start_stamp;
      prod_in    = ms_product(elapsed_ff);
   end

   // free-running: elapsed then product settle before the result is read
   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      prod_ff    <= prod_in;
   end

   always_comb begin
      result.drive_mask      = drive_mask;
      result.open_state_mask = open_bits;
      result.valve_open      = idx_ok && pick.is_open;
      result.valve_enabled   = idx_ok && pick.enabled;
      result.valve_fault     = idx_ok && pick.fault;
      result.action_total    = idx_ok ? pick.count : 32'd0;
      if (!idx_ok) begin
         result.open_seconds = 32'd0;
      end else if (pick.is_open && pick.start_valid) begin
         result.open_seconds = pick.total + sec_of_product(prod_ff);
      end else begin
         result.open_seconds = pick.total;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/solenoid_valve_bank_interlock.sv]
// Top level of the solenoid valve bank interlock: lanes, sequencer, config and output register.
// An accepted request passes the MUL, ADD and DONE states; DONE holds it until the output register has room.
// Requests do not overlap: a new one is taken only once the last has left DONE, after the
// ms-to-seconds multiply (MUL) and the total update that follows it (ADD).
// A new request is taken while the previous result waits in the output register.
// Reset is synchronous: valves, flags, counters, config registers, state and response valid return to reset values.
`timescale 1ns / 1ps
`default_nettype none
module solenoid_valve_bank_interlock #(
   parameter int unsigned VALVE_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   svbi_req_if.sink         req_chan,
   svbi_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import svbi_pkg::*;

   logic [15:0] min_main_ff, min_vent_ff, min_circ_ff;
   logic [31:0] max_main_ff, max_vent_ff, max_circ_ff;
   logic [7:0]  no_mask_ff;

   ctrl_state_type state_ff, state_in;
   logic           accept, load;
   logic [2:0]     idx_ff;
   logic [31:0]    now_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_data_type   rsp_data_ff;
   rsp_data_type   merged;
   lane_stat_type  stat [VALVE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_main_ff <= MIN_MAIN_RESET;
         max_main_ff <= MAX_MAIN_RESET;
         min_vent_ff <= MIN_VENT_RESET;
         max_vent_ff <= MAX_VENT_RESET;
         min_circ_ff <= MIN_CIRC_RESET;
         max_circ_ff <= MAX_CIRC_RESET;
         no_mask_ff  <= NO_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_MAIN: min_main_ff <= csr_write_data[15:0];
            CSR_MAX_MAIN: max_main_ff <= csr_write_data;
            CSR_MIN_VENT: min_vent_ff <= csr_write_data[15:0];
            CSR_MAX_VENT: max_vent_ff <= csr_write_data;
            CSR_MIN_CIRC: min_circ_ff <= csr_write_data[15:0];
            CSR_MAX_CIRC: max_circ_ff <= csr_write_data;
            CSR_NO_MASK:  no_mask_ff  <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_chan.ready   = 1'b0;
      load             = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_DONE;
         ST_DONE: begin
            // wait for room in the output register
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign accept       = req_chan.valid && req_chan.ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= req_chan.valve_index;
         now_ff <= req_chan.now_ms;
      end
      if (load) begin
         rsp_data_ff <= merged;
      end
   end

   for (genvar v = 0; v < VALVE_COUNT; v++) begin : g_lane
      localparam group_type GRP = group_of(v);
      lane_ctl_type ctl;
      logic [15:0]  min_ms;
      logic [31:0]  max_ms;

      always_comb begin
         case (GRP)
            GRP_MAIN: begin
               min_ms = min_main_ff;
               max_ms = max_main_ff;
            end
            GRP_VENT: begin
               min_ms = min_vent_ff;
               max_ms = max_vent_ff;
            end
            default: begin
               min_ms = min_circ_ff;
               max_ms = max_circ_ff;
            end
         endcase
      end

      assign ctl.take       = accept;
      assign ctl.op         = req_chan.opcode;
      assign ctl.hit        = (req_chan.valve_index == 3'(v));
      assign ctl.open_cmd   = req_chan.open_command;
      assign ctl.en_cmd     = req_chan.enable_command;
      assign ctl.sel        = req_chan.select_mask[v];
      assign ctl.batch_open = req_chan.batch_open_bits[v];
      assign ctl.now        = req_chan.now_ms;
      assign ctl.acc        = (state_ff == ST_ADD);

      svbi_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .reset_open (NO_MASK_RESET[v]),
         .min_ms     (min_ms),
         .max_ms     (max_ms),
         .ctl        (ctl),
         .stat       (stat[v])
      );
   end

   svbi_merge #(
      .VALVE_COUNT (VALVE_COUNT)
   ) u_merge (
      .clock   (clock),
      .stat    (stat),
      .idx     (idx_ff),
      .now     (now_ff),
      .no_mask (no_mask_ff),
      .result  (merged)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.drive_mask      = rsp_data_ff.drive_mask;
   assign rsp_chan.open_state_mask = rsp_data_ff.open_state_mask;
   assign rsp_chan.valve_open      = rsp_data_ff.valve_open;
   assign rsp_chan.valve_enabled   = rsp_data_ff.valve_enabled;
   assign rsp_chan.valve_fault     = rsp_data_ff.valve_fault;
   assign rsp_chan.action_total    = rsp_data_ff.action_total;
   assign rsp_chan.open_seconds    = rsp_data_ff.open_seconds;

endmodule
`default_nettype wire

[hw/rtl/svbi_checker.sv]
// Port-level checks for the valve bank interlock, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module svbi_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] open_state_mask,
   input wire logic [7:0] drive_mask,
   input wire logic       valve_open,
   input wire logic       valve_enabled,
   input wire logic       valve_fault
);

   // an open valve can only have been opened while enabled and fault free
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && valve_open |-> valve_enabled && !valve_fault)
      else $error("open valve reported disabled or faulted");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && valve_open |-> open_state_mask != 8'd0)
      else $error("addressed valve open but state mask empty");

   // one request in flight: no back-to-back accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drive_mask))
      else $error("stalled response dropped or changed");

endmodule

bind solenoid_valve_bank_interlock svbi_checker u_svbi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .open_state_mask (rsp_chan.open_state_mask),
   .drive_mask      (rsp_chan.drive_mask),
   .valve_open      (rsp_chan.valve_open),
   .valve_enabled   (rsp_chan.valve_enabled),
   .valve_fault     (rsp_chan.valve_fault)
);
`default_nettype wire
